// File: sv/lrgd_pkg.sv
// shared types, constants and arithmetic helpers of the regression engine
`default_nettype none
package lrgd_pkg;

  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_MAX_COLUMNS = 16;
  localparam int COL_BITS        = 4;

  localparam logic [15:0] LR_RESET     = 16'd5243;
  localparam logic [15:0] EPOCHS_RESET = 16'd1000;
  localparam logic [4:0]  COLS_RESET   = 5'd2;

  typedef enum logic [1:0] {
    REG_LEARN_RATE  = 2'd0,
    REG_EPOCH_COUNT = 2'd1,
    REG_COLUMNS     = 2'd2
  } lrgd_reg_e;

  typedef enum logic [1:0] {
    LS_OK       = 2'd0,
    LS_OVERFLOW = 2'd1,
    LS_PARTIAL  = 2'd2
  } lrgd_status_e;

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_EPOCH, S_RD, S_PMUL, S_CHAIN, S_ERR, S_GMUL,
    S_GACC, S_DIV, S_DIVW, S_STEP, S_UPD, S_MSE, S_MSEW, S_OUT
  } lrgd_state_e;

  // strobes from the sequencer to every cell
  typedef struct packed {
    logic clear_w;
    logic clear_g;
    logic load_x;
    logic mul_w;
    logic mul_e;
    logic acc_g;
    logic upd_w;
  } lrgd_ctl_t;

  function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/lrgd_cell.sv
// one column cell: feature latch, weight, gradient sum and a link of the dot-product chain
`default_nettype none
module lrgd_cell import lrgd_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  lrgd_ctl_t                    ctl_i,
  input  wire        [COL_BITS-1:0]    feats_i,
  input  wire        [COL_BITS-1:0]    x_sel_i,
  input  wire  signed [31:0]           x_i,
  input  wire  signed [31:0]           err_i,
  input  wire        [COL_BITS-1:0]    w_sel_i,
  input  wire  signed [31:0]           w_new_i,
  input  wire  signed [63:0]           acc_i,
  output logic signed [63:0]           acc_o,
  output logic signed [31:0]           w_o,
  output logic signed [31:0]           x_o,
  output logic signed [63:0]           g_o
);

  localparam logic [COL_BITS-1:0] MY_IDX = COL_BITS'(CELL_IDX);

  logic signed [31:0] x_q, w_q, mul_a;
  logic signed [63:0] g_q, prod_q, prod_d, acc_q;
  logic               is_feat, is_bias;

  assign is_feat = MY_IDX < feats_i;
  assign is_bias = MY_IDX == feats_i;
  assign mul_a   = ctl_i.mul_e ? err_i : w_q;

  always_comb begin
    if (ctl_i.mul_e && is_bias) prod_d = {{16{err_i[31]}}, err_i, 16'd0};
    else prod_d = mul_a * x_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
      g_q <= '0;
    end else begin
      if (ctl_i.clear_w) w_q <= '0;
      else if (ctl_i.upd_w && w_sel_i == MY_IDX) w_q <= w_new_i;
      if (ctl_i.clear_g) g_q <= '0;
      else if (ctl_i.acc_g && (is_feat || is_bias)) g_q <= add_sat64(g_q, prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_x && x_sel_i == MY_IDX) x_q <= x_i;
    if (ctl_i.mul_w || ctl_i.mul_e) prod_q <= prod_d;
    acc_q <= is_feat ? add_sat64(acc_i, prod_q) : acc_i;
  end

  assign acc_o = acc_q;
  assign w_o   = w_q;
  assign x_o   = x_q;
  assign g_o   = g_q;

endmodule
`default_nettype wire

// File: sv/lrgd_div.sv
// restoring divider, one quotient bit per cycle, 64-bit dividend
`default_nettype none
module lrgd_div #(
  parameter int DW = 11
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  wire  [63:0]   num_i,
  input  wire  [DW-1:0] den_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [63:0]   quo_o
);

  logic [63:0] quo_q;
  logic [DW:0] rem_q, trial;
  logic [DW-1:0] den_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;

  assign trial = {rem_q[DW-1:0], quo_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// File: sv/linear_regression_gradient_descent.sv
// batch gradient-descent linear regression engine: sample memory, cell row, sequencer
// loading takes one word per cycle; the run starts on the word flagged tlast
// training per epoch: a cell row pass over every row, then for each column
//   a gradient division on the shared 64-step divider and the weight step
// the final mse takes one more division, then one result word per column goes out
// input is held off from tlast until the last result word is taken
// asynchronous active-low reset clears weights, sums and counters and presets config
`default_nettype none
module linear_regression_gradient_descent import lrgd_pkg::*; #(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [31:0]  s_axis_tdata,   // sample_value
  input  wire          s_axis_tlast,   // set_end
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [103:0] m_axis_tdata,   // weight_index, weight_value, mean_sq_error, zero pad
  output logic [1:0]   m_axis_tuser,   // status
  output logic         m_axis_tlast,   // last_weight
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [1:0]   cfg_index_i,
  input  wire  [15:0]  cfg_data_i
);

  localparam int NC    = (MAX_COLUMNS < 16) ? MAX_COLUMNS : 16;
  localparam int IW    = $clog2(NC);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  // config registers
  logic [15:0] lr_q, epochs_q;
  logic [4:0]  cols_cfg_q, cols;
  logic [COL_BITS-1:0] feats;

  // sequencer state
  lrgd_state_e state_q, state_d;
  logic [RW-1:0] rows_q, rows_d, row_idx_q, row_idx_d;
  logic [COL_BITS-1:0] colpos_q, colpos_d, chain_q, chain_d, j_q, j_d;
  logic [1:0]  status_q, status_d;
  logic [4:0]  rd_q, rd_d;
  logic [15:0] epoch_q, epoch_d;

  // datapath registers
  logic signed [31:0] err_q, err_d;
  logic [62:0] esum_q, esum_d, mse_q, mse_d;
  logic [48:0] step_q, step_d;

  // memory
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] waddr, raddr;

  // cell row
  lrgd_ctl_t          ctl;
  logic signed [63:0] acc_vec [NC+1];
  logic signed [31:0] w_vec [NC];
  logic signed [31:0] x_vec [NC];
  logic signed [63:0] g_vec [NC];
  logic signed [31:0] w_new;

  // divider
  logic          div_start, div_busy, div_done;
  logic [63:0]   div_num, div_quo;

  logic in_fire, row_end, has_room;
  logic signed [63:0] acc_fin, g_sel, pred, diff, step_s, nw;
  logic [63:0] mag, rsum, g_mag;
  logic [63:0] sq;
  logic [63:0] esum_sum;
  logic [47:0] hi_p, lo_p;

  // clamp the column count to between two and the width of the cell row
  always_comb begin
    cols = cols_cfg_q;
    if (cols < 5'd2) cols = 5'd2;
    if (32'(cols) > NC) cols = 5'(NC);
  end
  assign feats = COL_BITS'(cols - 5'd1);

  // config port always takes a write
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q       <= LR_RESET;
      epochs_q   <= EPOCHS_RESET;
      cols_cfg_q <= COLS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LEARN_RATE:  lr_q       <= cfg_data_i;
        REG_EPOCH_COUNT: epochs_q   <= cfg_data_i;
        REG_COLUMNS:     cols_cfg_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // load path
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign has_room = 32'(rows_q) < MAX_ROWS;
  assign row_end  = ({1'b0, colpos_q} + 5'd1) >= cols;
  assign mem_we   = in_fire && has_room && (32'(colpos_q) < MAX_COLUMNS);
  assign waddr    = AW'(32'(rows_q) * MAX_COLUMNS + 32'(colpos_q));
  assign raddr    = AW'(32'(row_idx_q) * MAX_COLUMNS + 32'(rd_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= s_axis_tdata;
    rdata_q <= mem[raddr];
  end

  // dot-product chain starts from the bias in q32.32
  assign acc_vec[0] = {{16{w_vec[feats[IW-1:0]][31]}}, w_vec[feats[IW-1:0]], 16'd0};

  for (genvar c = 0; c < NC; c++) begin : g_cell
    lrgd_cell #(.CELL_IDX(c)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .feats_i (feats),
      .x_sel_i (COL_BITS'(rd_q - 5'd1)),
      .x_i     (rdata_q),
      .err_i   (err_q),
      .w_sel_i (j_q),
      .w_new_i (w_new),
      .acc_i   (acc_vec[c]),
      .acc_o   (acc_vec[c+1]),
      .w_o     (w_vec[c]),
      .x_o     (x_vec[c]),
      .g_o     (g_vec[c])
    );
  end

  lrgd_div #(.DW(RW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (rows_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // prediction rounding and error
  assign acc_fin = acc_vec[NC];
  assign mag     = acc_fin[63] ? 64'(-acc_fin) : 64'(acc_fin);
  assign rsum    = mag + 64'h8000;
  assign pred    = acc_fin[63] ? -$signed({16'd0, rsum[63:16]}) : $signed({16'd0, rsum[63:16]});
  assign diff    = pred - 64'(x_vec[feats[IW-1:0]]);

  // squared error, saturating at 2^63-1
  assign sq       = 64'(err_q) * 64'(err_q);
  assign esum_sum = {1'b0, esum_q} + {1'b0, sq[62:0]};

  // gradient magnitude for the divider, weight step from the mean
  assign g_sel  = g_vec[j_q[IW-1:0]];
  assign g_mag  = g_sel[63] ? 64'(-g_sel) : 64'(g_sel);
  assign hi_p   = lr_q * div_quo[63:32];
  assign lo_p   = lr_q * div_quo[31:0];
  assign step_s = g_sel[63] ? -$signed({15'd0, step_q}) : $signed({15'd0, step_q});
  assign nw     = 64'(w_vec[j_q[IW-1:0]]) - step_s;
  assign w_new  = clamp32(nw);

  always_comb begin
    state_d   = state_q;
    rows_d    = rows_q;
    row_idx_d = row_idx_q;
    colpos_d  = colpos_q;
    chain_d   = chain_q;
    j_d       = j_q;
    status_d  = status_q;
    rd_d      = rd_q;
    epoch_d   = epoch_q;
    err_d     = err_q;
    esum_d    = esum_q;
    mse_d     = mse_q;
    step_d    = step_q;
    ctl       = '0;
    div_start = 1'b0;
    div_num   = g_mag;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          if (!has_room) status_d = LS_OVERFLOW;
          colpos_d = row_end ? '0 : colpos_q + 1'b1;
          if (row_end && has_room) rows_d = rows_q + 1'b1;
          if (s_axis_tlast) begin
            if (!row_end) status_d = LS_PARTIAL;
            state_d = S_START;
          end
        end
      end
      S_START: begin
        ctl.clear_w = 1'b1;
        esum_d  = '0;
        epoch_d = '0;
        if (rows_q == '0 || epochs_q == '0) begin
          mse_d   = '0;
          j_d     = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_EPOCH;
        end
      end
      S_EPOCH: begin
        ctl.clear_g = 1'b1;
        esum_d    = '0;
        row_idx_d = '0;
        rd_d      = '0;
        state_d   = S_RD;
      end
      S_RD: begin
        // one read a cycle, the read data is registered in rdata_q and then latched by the cell
        ctl.load_x = rd_q != 5'd0;
        rd_d = rd_q + 5'd1;
        if (rd_q == cols) state_d = S_PMUL;
      end
      S_PMUL: begin
        ctl.mul_w = 1'b1;
        chain_d   = '0;
        state_d   = S_CHAIN;
      end
      S_CHAIN: begin
        chain_d = chain_q + 1'b1;
        if (32'(chain_q) == NC - 1) state_d = S_ERR;
      end
      S_ERR: begin
        err_d   = clamp32(diff);
        state_d = S_GMUL;
      end
      S_GMUL: begin
        ctl.mul_e = 1'b1;
        esum_d    = esum_sum[63] ? {63{1'b1}} : esum_sum[62:0];
        state_d   = S_GACC;
      end
      S_GACC: begin
        ctl.acc_g = 1'b1;
        row_idx_d = row_idx_q + 1'b1;
        rd_d      = '0;
        j_d       = '0;
        state_d   = (row_idx_q + 1'b1 == rows_q) ? S_DIV : S_RD;
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) state_d = S_STEP;
      end
      S_STEP: begin
        step_d  = {1'b0, hi_p} + 49'(({16'd0, lo_p} + 64'h8000_0000) >> 32);
        state_d = S_UPD;
      end
      S_UPD: begin
        ctl.upd_w = 1'b1;
        if ({1'b0, j_q} + 5'd1 == cols) begin
          epoch_d = epoch_q + 16'd1;
          state_d = ({1'b0, epoch_q} + 17'd1 == {1'b0, epochs_q}) ? S_MSE : S_EPOCH;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_DIV;
        end
      end
      S_MSE: begin
        div_start = 1'b1;
        div_num   = {1'b0, esum_q};
        state_d   = S_MSEW;
      end
      S_MSEW: begin
        if (div_done) begin
          mse_d   = div_quo[62:0];
          j_d     = '0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if ({1'b0, j_q} + 5'd1 == cols) begin
            rows_d   = '0;
            colpos_d = '0;
            status_d = LS_OK;
            epoch_d  = '0;
            state_d  = S_LOAD;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      rows_q    <= '0;
      row_idx_q <= '0;
      colpos_q  <= '0;
      chain_q   <= '0;
      j_q       <= '0;
      status_q  <= LS_OK;
      rd_q      <= '0;
      epoch_q   <= '0;
      esum_q    <= '0;
      mse_q     <= '0;
    end else begin
      state_q   <= state_d;
      rows_q    <= rows_d;
      row_idx_q <= row_idx_d;
      colpos_q  <= colpos_d;
      chain_q   <= chain_d;
      j_q       <= j_d;
      status_q  <= status_d;
      rd_q      <= rd_d;
      epoch_q   <= epoch_d;
      esum_q    <= esum_d;
      mse_q     <= mse_d;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    step_q <= step_d;
  end

  // result word
  assign m_axis_tdata = {5'd0, mse_q, w_vec[j_q[IW-1:0]], j_q};
  assign m_axis_tuser = status_q;
  assign m_axis_tlast = ({1'b0, j_q} + 5'd1) == cols;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while results pending");
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, j_q} < cols))
    else $error("result index beyond column count");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_hold_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(j_q))
    else $error("result index moved under stall");
`endif

endmodule
`default_nettype wire
